>>> rtl/pans_pkg.sv
// Shared types, constants and helpers for the PWM audio noise shaper.
package pans_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned LEVEL_W  = 10;
    localparam int unsigned RESID_W  = 6;
    localparam int unsigned VOL_W    = 7;
    localparam int unsigned DIV_W    = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 7;

    localparam int unsigned OUT_DEPTH_DEFAULT = 4;

    localparam logic [CFG_IDX_W-1:0] REG_VOLUME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = 2'd2;

    localparam logic [VOL_W-1:0]   VOL_RESET     = 7'd100;
    localparam logic [DIV_W-1:0]   DIV_RESET     = 4'd2;
    localparam logic [LEVEL_W-1:0] MID_SHAPED    = 10'd512;
    localparam logic [LEVEL_W-1:0] MID_PLAIN     = 10'd128;

    // ceil(2^30 / 100): exact truncating divide for magnitudes below 2^23
    localparam logic [23:0]        RECIP_100   = 24'd10737419;
    localparam int unsigned        RECIP_SHIFT = 30;

    localparam logic [SAMPLE_W-1:0] OFFSET_BIT = 16'h8000;

    typedef struct packed {
        logic valid;
        logic take;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               taken;
    } out_item_t;

    // Clamp an 18-bit signed value to the 16-bit signed range
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/pans_scaler.sv
// Two-stage volume scaler: sample times percent, then divide by one hundred.
module pans_scaler (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pans_pkg::pipe_ctrl_t           in_ctrl,
    input  logic signed [15:0]             in_sample,
    input  logic [pans_pkg::VOL_W-1:0]     volume,
    output pans_pkg::pipe_ctrl_t           out_ctrl,
    output logic signed [15:0]             out_scaled
);

    logic signed [23:0] prod;
    logic        [23:0] prod_mag;
    logic        [22:0] mag_reg;
    logic               neg_reg;
    pans_pkg::pipe_ctrl_t ctrl1_reg;

    logic        [46:0] recip_prod;
    logic        [16:0] quot_reg;
    logic               neg2_reg;
    pans_pkg::pipe_ctrl_t ctrl2_reg;

    logic signed [17:0] signed_quot;

    assign prod     = 24'(in_sample) * 24'($signed({1'b0, volume}));
    assign prod_mag = prod[23] ? 24'(-prod) : 24'(prod);

    assign recip_prod = 47'(mag_reg) * 47'(pans_pkg::RECIP_100);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
        end else begin
            ctrl1_reg <= in_ctrl;
            ctrl2_reg <= ctrl1_reg;
        end
        mag_reg  <= prod_mag[22:0];
        neg_reg  <= prod[23];
        quot_reg <= recip_prod[pans_pkg::RECIP_SHIFT +: 17];
        neg2_reg <= neg_reg;
    end

    // Restore the sign; truncation toward zero falls out of dividing the magnitude
    assign signed_quot = neg2_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});

    assign out_ctrl   = ctrl2_reg;
    assign out_scaled = pans_pkg::sat16(signed_quot);

endmodule

>>> rtl/pans_out_fifo.sv
// Small result queue decoupling the processing pipeline from the output channel.
module pans_out_fifo #(
    parameter int unsigned DEPTH = pans_pkg::OUT_DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  pans_pkg::out_item_t             push_data,
    input  logic                            pop,
    output logic                            out_valid,
    output pans_pkg::out_item_t             out_data,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH+1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    pans_pkg::out_item_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign count     = count_reg;

endmodule

>>> rtl/pwm_audio_noise_shaper_top.sv
// Top level of the PWM audio requantizer with first-order noise shaping.
//
// Usage:
//   s_ channel: one transaction per PWM period tick. s_tuser carries the
//   sample-ready flag, s_tdata the signed 16-bit left sample.
//   m_ channel: one transaction per tick, in order. m_tdata carries the duty
//   level held before that tick's update, m_tuser the sample-taken flag.
//   cfg channel: register writes (volume, mode, divider), ready whenever out
//   of reset; write only while no tick is in flight.
// Throughput: one tick per cycle while s_tready is high. Ticks pass a multiply
// stage and a reciprocal-divide stage, both registered, and are registered again in
// a queue of OUT_DEPTH entries before showing on m_; shaping is done as the result
// enters the queue; s_tready drops once queued plus in-flight ticks fill it.
// When m_tready stays low the queue fills and s_tready falls after at most
// OUT_DEPTH accepted ticks; nothing is lost.
// Reset: volume 100, shaped mode, divider 2, level 512 (midscale), residual
// and tick counter cleared, queue emptied; s_tready and cfg_ready stay low.
// A mode write reloads midscale.
module pwm_audio_noise_shaper_top #(
    parameter int unsigned OUT_DEPTH = pans_pkg::OUT_DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // slave side
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [15:0]                          s_tdata,   // [15:0] left_sample
    input  logic [0:0]                           s_tuser,   // [0] sample_ready
    // master side
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [15:0]                          m_tdata,   // [9:0] pwm_level, [15:10] zero
    output logic [0:0]                           m_tuser,   // [0] sample_taken
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pans_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pans_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned CNT_W = $clog2(OUT_DEPTH+1);

    logic [pans_pkg::VOL_W-1:0]   volume_reg;
    logic                         shaped_reg;
    logic [pans_pkg::DIV_W-1:0]   divider_reg;
    logic [pans_pkg::DIV_W-1:0]   tick_count_reg, tick_count_next;
    logic [pans_pkg::LEVEL_W-1:0] held_level_reg, held_level_next;
    logic [pans_pkg::RESID_W-1:0] residual_reg, residual_next;

    logic                         s_accept;
    logic                         cfg_accept;
    logic [pans_pkg::DIV_W:0]     tick_inc;
    logic                         dividing;
    pans_pkg::pipe_ctrl_t         in_ctrl;
    pans_pkg::pipe_ctrl_t         sc_ctrl;
    logic signed [15:0]           sc_scaled;

    logic signed [17:0]           shaped_sum;
    logic signed [15:0]           shaped_sat;
    logic [15:0]                  shaped_u;
    logic [15:0]                  plain_u;

    pans_pkg::out_item_t          push_item;
    pans_pkg::out_item_t          head_item;
    logic [CNT_W-1:0]             q_count;
    logic [CNT_W:0]               occupancy;
    logic                         pop;

    pans_pkg::pipe_ctrl_t         s1_ctrl_reg;

    assign cfg_ready  = aresetn;
    assign cfg_accept = cfg_valid && cfg_ready;

    // Ticks in the pipeline hold a queue slot already
    assign occupancy = (CNT_W+1)'(q_count) + (CNT_W+1)'(s1_ctrl_reg.valid)
                     + (CNT_W+1)'(sc_ctrl.valid);
    assign s_tready  = aresetn && (occupancy < (CNT_W+1)'(OUT_DEPTH));
    assign s_accept  = s_tvalid && s_tready;

    assign tick_inc = {1'b0, tick_count_reg} + (pans_pkg::DIV_W+1)'(1);
    assign dividing = (tick_inc >= {1'b0, divider_reg});

    always_comb begin
        tick_count_next = tick_count_reg;
        if (s_accept) begin
            tick_count_next = dividing ? '0 : tick_inc[pans_pkg::DIV_W-1:0];
        end
    end

    assign in_ctrl.valid = s_accept;
    assign in_ctrl.take  = s_accept && dividing && s_tuser[0];

    pans_scaler u_scaler (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_ctrl    (in_ctrl),
        .in_sample  ($signed(s_tdata)),
        .volume     (volume_reg),
        .out_ctrl   (sc_ctrl),
        .out_scaled (sc_scaled)
    );

    // Track the scaler's first stage for the occupancy count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctrl_reg <= '0;
        end else begin
            s1_ctrl_reg <= in_ctrl;
        end
    end

    assign shaped_sum = {{2{sc_scaled[15]}}, sc_scaled} + {12'b0, residual_reg};
    assign shaped_sat = pans_pkg::sat16(shaped_sum);
    assign shaped_u   = shaped_sat ^ pans_pkg::OFFSET_BIT;
    assign plain_u    = sc_scaled ^ pans_pkg::OFFSET_BIT;

    always_comb begin
        held_level_next = held_level_reg;
        residual_next   = residual_reg;
        if (cfg_accept && cfg_index == pans_pkg::REG_MODE) begin
            held_level_next = cfg_data[0] ? pans_pkg::MID_SHAPED : pans_pkg::MID_PLAIN;
            residual_next   = '0;
        end else if (sc_ctrl.valid && sc_ctrl.take) begin
            if (shaped_reg) begin
                held_level_next = shaped_u[15:6];
                residual_next   = shaped_u[5:0];
            end else begin
                held_level_next = {2'b00, plain_u[15:8]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_reg     <= pans_pkg::VOL_RESET;
            shaped_reg     <= 1'b1;
            divider_reg    <= pans_pkg::DIV_RESET;
            tick_count_reg <= '0;
            held_level_reg <= pans_pkg::MID_SHAPED;
            residual_reg   <= '0;
        end else begin
            tick_count_reg <= tick_count_next;
            held_level_reg <= held_level_next;
            residual_reg   <= residual_next;
            if (cfg_accept) begin
                case (cfg_index)
                    pans_pkg::REG_VOLUME:  volume_reg  <= cfg_data[pans_pkg::VOL_W-1:0];
                    pans_pkg::REG_MODE:    shaped_reg  <= cfg_data[0];
                    pans_pkg::REG_DIVIDER: divider_reg <= cfg_data[pans_pkg::DIV_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Emit the level held before this tick's update
    assign push_item.level = held_level_reg;
    assign push_item.taken = sc_ctrl.take;

    assign pop = m_tvalid && m_tready;

    pans_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (sc_ctrl.valid),
        .push_data (push_item),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_data  (head_item),
        .count     (q_count)
    );

    assign m_tdata = {6'b0, head_item.level};
    assign m_tuser = head_item.taken;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= (CNT_W+1)'(OUT_DEPTH))
        else $error("result queue over-committed");

    a_plain_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !shaped_reg |-> (held_level_reg[9:8] == 2'b00 && residual_reg == '0))
        else $error("plain mode level out of 8-bit range or residual set");

    a_tick_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_count_reg != 4'hf)
        else $error("tick counter beyond largest divider");

    a_take_needs_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ctrl.take |-> (s_accept && s_tuser[0] && dividing))
        else $error("sample taken without dividing tick and ready sample");
`endif

endmodule

>>> tb/sv/tb_pwm_audio_noise_shaper_top.sv
// Self-checking testbench for the PWM audio noise shaper: predicted duty levels vs. the stream.
`timescale 1ns / 1ps

module tb_pwm_audio_noise_shaper_top;

    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned PRINT_LIMIT = 50;

    // Index with no register behind it
    localparam logic [pans_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    // Tracks tick counter, held level and residual; queues the levels due on m_.
    class duty_scoreboard;
        logic [pans_pkg::VOL_W-1:0]   volume;
        logic                         shaped;
        logic [pans_pkg::DIV_W-1:0]   divider;
        int                           tick_count;
        logic [pans_pkg::LEVEL_W-1:0] level;
        logic [pans_pkg::RESID_W-1:0] residual;
        pans_pkg::out_item_t          due_levels[$];
        int                           errors;

        function new();
            volume     = pans_pkg::VOL_RESET;
            shaped     = 1'b1;
            divider    = pans_pkg::DIV_RESET;
            tick_count = 0;
            level      = pans_pkg::MID_SHAPED;
            residual   = '0;
            errors     = 0;
        endfunction

        function void apply_write(logic [pans_pkg::CFG_IDX_W-1:0] idx,
                                  logic [pans_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                pans_pkg::REG_VOLUME: begin
                    volume = data[pans_pkg::VOL_W-1:0];
                end
                pans_pkg::REG_MODE: begin
                    shaped   = data[0];
                    level    = data[0] ? pans_pkg::MID_SHAPED : pans_pkg::MID_PLAIN;
                    residual = '0;
                end
                pans_pkg::REG_DIVIDER: begin
                    divider = data[pans_pkg::DIV_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void take_tick(bit ready, logic signed [15:0] sample);
            pans_pkg::out_item_t due;
            int                  next_count;
            int                  scaled;
            int                  sum;
            logic [15:0]         offs;
            due.level  = level;
            due.taken  = 1'b0;
            next_count = tick_count + 1;
            if (next_count >= int'(divider)) begin
                tick_count = 0;
                if (ready) begin
                    due.taken = 1'b1;
                    // integer divide truncates toward zero, as the hardware must
                    scaled = (int'(sample) * int'(volume)) / 100;
                    if (scaled > 32767) scaled = 32767;
                    else if (scaled < -32768) scaled = -32768;
                    if (shaped) begin
                        sum = scaled + int'(residual);
                        if (sum > 32767) sum = 32767;
                        else if (sum < -32768) sum = -32768;
                        offs     = 16'(sum + 32768);
                        level    = offs[15:6];
                        residual = offs[5:0];
                    end else begin
                        offs  = 16'(scaled + 32768);
                        level = {2'b00, offs[15:8]};
                    end
                end
            end else begin
                tick_count = next_count;
            end
            due_levels.push_back(due);
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_level(logic [pans_pkg::LEVEL_W-1:0] got_level, logic got_taken);
            pans_pkg::out_item_t due;
            if (due_levels.size() == 0) begin
                report($sformatf("unexpected result level=%0d taken=%0b", got_level, got_taken));
            end else begin
                due = due_levels.pop_front();
                if (got_level !== due.level)
                    report($sformatf("pwm_level %0d, expected %0d", got_level, due.level));
                if (got_taken !== due.taken)
                    report($sformatf("sample_taken %0b, expected %0b", got_taken, due.taken));
            end
        endtask

        function int pending();
            return due_levels.size();
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [15:0]                     s_tdata   = '0;   // [15:0] left_sample
    logic [0:0]                      s_tuser   = '0;   // [0] sample_ready
    logic                            m_tvalid;
    logic                            m_tready  = 1'b1;
    logic [15:0]                     m_tdata;          // [9:0] pwm_level, [15:10] zero
    logic [0:0]                      m_tuser;          // [0] sample_taken
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pans_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pans_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    duty_scoreboard sb;
    bit             no_gaps = 1'b0;

    pwm_audio_noise_shaper_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic send_tick(input bit ready, input logic [15:0] sample);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= ready;
        do @(posedge aclk); while (!s_tready);
        sb.take_tick(ready, sample);
    endtask

    // Leaves cfg_valid high; settle() drops it once the writes are done.
    task automatic write_reg(input logic [pans_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pans_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.apply_write(idx, data);
    endtask

    // Drop both valids and hold until every queued level has come back.
    task automatic settle();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Result side: accept, then stall for a drawn number of cycles.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_level(m_tdata[pans_pkg::LEVEL_W-1:0], m_tuser[0]);
                stall = draw_gap();
                m_tready <= (stall == 0);
            end else if (!m_tready) begin
                stall--;
                if (stall <= 0) m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("** pwm_audio_noise_shaper_top: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int          n_items;
        bit          ready;
        logic [15:0] sample;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: extremes, zero, underrun, one LSB either side of zero
        send_tick(1'b1, 16'h7fff);
        send_tick(1'b1, 16'h7fff);
        send_tick(1'b1, 16'h8000);
        send_tick(1'b1, 16'h8000);
        send_tick(1'b1, 16'h0000);
        send_tick(1'b0, 16'h1234);
        send_tick(1'b0, 16'hedcb);
        send_tick(1'b1, 16'hffff);
        send_tick(1'b1, 16'hffff);
        send_tick(1'b1, 16'h0001);
        send_tick(1'b1, 16'h0001);
        settle();

        // volume over one hundred saturates; divider zero takes every tick; plain mode
        write_reg(pans_pkg::REG_VOLUME, 7'd127);
        write_reg(pans_pkg::REG_DIVIDER, 7'd0);
        write_reg(pans_pkg::REG_MODE, 7'd0);
        write_reg(REG_UNMAPPED, 7'h55);
        settle();
        send_tick(1'b1, 16'h7fff);
        send_tick(1'b1, 16'h8000);
        send_tick(1'b1, 16'hffff);
        send_tick(1'b0, 16'h7fff);
        send_tick(1'b1, 16'h0000);
        settle();

        // mute, shaped again, slowest divider; then lower it below the count
        write_reg(pans_pkg::REG_VOLUME, 7'd0);
        write_reg(pans_pkg::REG_MODE, 7'h7f);
        write_reg(pans_pkg::REG_DIVIDER, 7'd15);
        settle();
        repeat (6) send_tick(1'b1, 16'($urandom));
        settle();
        write_reg(pans_pkg::REG_VOLUME, 7'd99);
        write_reg(pans_pkg::REG_DIVIDER, 7'd3);
        settle();
        send_tick(1'b1, 16'hffff);
        send_tick(1'b1, 16'h8001);
        settle();

        for (int phase = 0; phase < 14; phase++) begin
            case ($urandom_range(0, 5))
                0: write_reg(pans_pkg::REG_VOLUME, 7'd0);
                1: write_reg(pans_pkg::REG_VOLUME, 7'd100);
                2: write_reg(pans_pkg::REG_VOLUME, 7'd127);
                3: write_reg(pans_pkg::REG_VOLUME, 7'($urandom_range(90, 110)));
                default: write_reg(pans_pkg::REG_VOLUME, 7'($urandom_range(0, 127)));
            endcase
            if ($urandom_range(0, 1)) write_reg(pans_pkg::REG_MODE, 7'($urandom));
            // upper data bits are don't-care for the divider
            case ($urandom_range(0, 5))
                0: write_reg(pans_pkg::REG_DIVIDER, {3'($urandom), 4'd0});
                1: write_reg(pans_pkg::REG_DIVIDER, {3'($urandom), 4'd15});
                2: write_reg(pans_pkg::REG_DIVIDER, {3'($urandom), 4'd1});
                default: write_reg(pans_pkg::REG_DIVIDER,
                                   {3'($urandom), 4'($urandom_range(0, 4))});
            endcase
            if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, 7'($urandom));
            no_gaps = (phase % 4 == 3);
            settle();
            n_items = $urandom_range(100, 160);
            for (int i = 0; i < n_items; i++) begin
                ready = ($urandom_range(0, 9) != 0);
                case ($urandom_range(0, 7))
                    0: sample = 16'h7fff;
                    1: sample = 16'h8000;
                    2: sample = 16'($urandom_range(0, 255) - 128);
                    default: sample = 16'($urandom);
                endcase
                send_tick(ready, sample);
            end
            settle();
            no_gaps = 1'b0;
        end

        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** pwm_audio_noise_shaper_top: PASSED **");
        end else begin
            $display("** pwm_audio_noise_shaper_top: FAILED **");
        end
        $finish;
    end

endmodule
